// ===== sv/ibmw_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and constants for the indirect block map walker.
// No dependencies; every other file of the block refers to this package.
package ibmw_pkg;

  localparam int unsigned DIRECT_SLOTS     = 12;
  localparam int unsigned MAX_ENTRIES_LOG2 = 14;
  localparam int unsigned MIN_ENTRIES_LOG2 = 8;
  localparam int unsigned IDX_W            = 14;
  localparam int unsigned WORD_W           = 32;
  localparam int unsigned LOG2_W           = 4;
  localparam int unsigned LEVELS           = 3;

  typedef enum logic {
    OP_START = 1'b0,
    OP_RESP  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    KIND_SLOT = 2'd0,
    KIND_WORD = 2'd1,
    KIND_DONE = 2'd2,
    KIND_ERR  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_READ  = 2'd1,
    ERR_RANGE = 2'd2,
    ERR_ORDER = 2'd3
  } err_t;

  // One input transaction as held in the input register.
  typedef struct packed {
    op_t                 operation;
    logic [WORD_W-1:0]   file_block;
    logic [WORD_W-1:0]   read_word;
    logic                read_failed;
  } item_t;

  // Decoded start request: tree depth, per-level word indices, inode slot.
  typedef struct packed {
    logic                beyond;
    logic [1:0]          depth;
    logic [IDX_W-1:0]    slot;
    logic [IDX_W-1:0]    idx0;
    logic [IDX_W-1:0]    idx1;
    logic [IDX_W-1:0]    idx2;
  } split_t;

  // Clamp the configured pointer count exponent to the supported range.
  function automatic logic [LOG2_W-1:0] eff_log2(input logic [LOG2_W-1:0] n);
    logic [LOG2_W-1:0] r;
    r = n;
    if (n < LOG2_W'(MIN_ENTRIES_LOG2)) r = LOG2_W'(MIN_ENTRIES_LOG2);
    if (n > LOG2_W'(MAX_ENTRIES_LOG2)) r = LOG2_W'(MAX_ENTRIES_LOG2);
    return r;
  endfunction

endpackage

// ===== sv/ibmw_index_split.sv =====
`timescale 1ns / 1ps
// Start-request decoder: tree depth and per-level word indices of a
// logical block. Combinational; uses ibmw_pkg.
module ibmw_index_split (
  input  logic [ibmw_pkg::WORD_W-1:0] file_block,
  input  logic [ibmw_pkg::LOG2_W-1:0] entries_log2,
  output ibmw_pkg::split_t            split
);

  always_comb begin
    logic [3:0]  n;
    logic [4:0]  n2;
    logic [5:0]  n3;
    logic [32:0] r;
    logic [32:0] e_val;
    logic [32:0] cap2;
    logic [32:0] r1;
    logic [32:0] r2;
    logic [13:0] m;
    n     = ibmw_pkg::eff_log2(entries_log2);
    n2    = {n, 1'b0};
    n3    = 6'(n) + 6'(n2);
    r     = {1'b0, file_block} - 33'(ibmw_pkg::DIRECT_SLOTS);
    e_val = 33'(1) << n;
    cap2  = 33'(1) << n2;
    r1    = r - e_val;
    r2    = r1 - cap2;
    m     = ~(14'h3FFF << n);

    split        = '0;
    split.depth  = 2'd0;
    split.slot   = file_block[ibmw_pkg::IDX_W-1:0];
    if (file_block >= 32'(ibmw_pkg::DIRECT_SLOTS)) begin
      if (r < e_val) begin
        split.depth = 2'd1;
        split.idx0  = 14'(r) & m;
      end else if (r1 < cap2) begin
        split.depth = 2'd2;
        split.idx0  = 14'(r1 >> n) & m;
        split.idx1  = 14'(r1) & m;
      end else if ((r2 >> n3) == 33'd0) begin
        split.depth = 2'd3;
        split.idx0  = 14'(r2 >> n2) & m;
        split.idx1  = 14'(r2 >> n) & m;
        split.idx2  = 14'(r2) & m;
      end else begin
        split.beyond = 1'b1;
      end
      // indirect trees start at the slot right after the direct ones
      split.slot = 14'(ibmw_pkg::DIRECT_SLOTS) + 14'(split.depth) - 14'd1;
    end
  end

endmodule

// ===== sv/ibmw_step.sv =====
`timescale 1ns / 1ps
// Walk state and result register: applies one transaction per cycle, unless the
// result is stalled, to the walk state and registers its result. Uses ibmw_pkg.
module ibmw_step (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         take,
  input  ibmw_pkg::item_t              item,
  input  ibmw_pkg::split_t             split,
  input  logic                         out_stall,
  output logic                         out_ready,
  output logic                         out_valid,
  output ibmw_pkg::kind_t              kind,
  output logic [ibmw_pkg::WORD_W-1:0]  fetch_block,
  output logic [ibmw_pkg::IDX_W-1:0]   fetch_index,
  output logic [ibmw_pkg::WORD_W-1:0]  mapped_block,
  output ibmw_pkg::err_t               error_code
);

  logic                        busy;
  logic [1:0]                  walk_depth;
  logic [1:0]                  walk_level;
  logic [ibmw_pkg::IDX_W-1:0]  level_index [ibmw_pkg::LEVELS];

  logic [ibmw_pkg::IDX_W-1:0]  cur_index;

  assign out_ready = !out_valid || !out_stall;

  always_comb begin
    case (walk_level)
      2'd0:    cur_index = level_index[0];
      2'd1:    cur_index = level_index[1];
      default: cur_index = level_index[2];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      busy       <= 1'b0;
      walk_depth <= 2'd0;
      walk_level <= 2'd0;
    end else begin
      if (take) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;

      if (take) begin
        fetch_block  <= '0;
        fetch_index  <= '0;
        mapped_block <= '0;
        error_code   <= ibmw_pkg::ERR_NONE;
        if (item.operation == ibmw_pkg::OP_START) begin
          if (busy) begin
            busy       <= 1'b0;
            kind       <= ibmw_pkg::KIND_ERR;
            error_code <= ibmw_pkg::ERR_ORDER;
          end else if (split.beyond) begin
            busy       <= 1'b0;
            kind       <= ibmw_pkg::KIND_ERR;
            error_code <= ibmw_pkg::ERR_RANGE;
          end else begin
            busy           <= 1'b1;
            walk_depth     <= split.depth;
            walk_level     <= 2'd0;
            level_index[0] <= split.idx0;
            level_index[1] <= split.idx1;
            level_index[2] <= split.idx2;
            kind           <= ibmw_pkg::KIND_SLOT;
            fetch_index    <= split.slot;
          end
        end else if (!busy) begin
          kind       <= ibmw_pkg::KIND_ERR;
          error_code <= ibmw_pkg::ERR_ORDER;
        end else if (item.read_failed) begin
          busy       <= 1'b0;
          kind       <= ibmw_pkg::KIND_ERR;
          error_code <= ibmw_pkg::ERR_READ;
        end else if (walk_level >= walk_depth || walk_level > 2'd2) begin
          busy         <= 1'b0;
          kind         <= ibmw_pkg::KIND_DONE;
          mapped_block <= item.read_word;
        end else if (item.read_word == '0) begin
          // hole in the tree
          busy <= 1'b0;
          kind <= ibmw_pkg::KIND_DONE;
        end else begin
          kind        <= ibmw_pkg::KIND_WORD;
          fetch_block <= item.read_word;
          fetch_index <= cur_index;
          walk_level  <= walk_level + 2'd1;
        end
      end
    end
  end

endmodule

// ===== sv/indirect_block_map_walker.sv =====
`timescale 1ns / 1ps
// Indirect block map walker: maps a file's logical block to a physical disk
// block through the ext2 inode pointer tree (12 direct slots, then single,
// double and triple indirect). Issue a start transaction with the logical
// block; the walker answers with the inode slot to fetch, then with one
// block/word to fetch per indirect level, each answered by a response
// transaction carrying the word read. Every input transaction yields exactly
// one result transaction: a fetch request, done (mapped block, 0 for a hole)
// or an error (failed read, beyond triple range, transaction out of order).
// The walker takes one transaction per cycle while the result is not stalled
// and presents its result from the result register: the input register feeds
// the decode and walk-state logic, whose outcome lands in the result register.
// The walk state is registered alongside it, so back-to-back transactions see
// each other's effect. A stalled result holds while one more transaction
// waits in the input register. entries_log2 is clamped to 8..14 and takes
// effect at the next start; write it only while no walk result is pending.
// Depends on ibmw_pkg, ibmw_index_split, ibmw_step.
module indirect_block_map_walker (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          cfg_we,
  input  logic [ibmw_pkg::LOG2_W-1:0]   cfg_wdata,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          operation,
  input  logic [ibmw_pkg::WORD_W-1:0]   file_block,
  input  logic [ibmw_pkg::WORD_W-1:0]   read_word,
  input  logic                          read_failed,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    kind,
  output logic [ibmw_pkg::WORD_W-1:0]   fetch_block,
  output logic [ibmw_pkg::IDX_W-1:0]    fetch_index,
  output logic [ibmw_pkg::WORD_W-1:0]   mapped_block,
  output logic [1:0]                    error_code
);

  logic [ibmw_pkg::LOG2_W-1:0] entries_log2;
  logic                        s1_valid;
  ibmw_pkg::item_t             s1_item;
  ibmw_pkg::split_t            split;
  logic                        out_ready;
  logic                        take;
  ibmw_pkg::kind_t             kind_reg;
  ibmw_pkg::err_t              err_reg;

  // Config register: plain write, clamp happens at use.
  always_ff @(posedge clk) begin
    if (rst) begin
      entries_log2 <= ibmw_pkg::LOG2_W'(ibmw_pkg::MIN_ENTRIES_LOG2);
    end else if (cfg_we) begin
      entries_log2 <= cfg_wdata;
    end
  end

  // Input register: advance whenever the result side can take its item.
  assign take     = s1_valid && out_ready;
  assign in_stall = s1_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
    if (in_valid && !in_stall) begin
      s1_item.operation   <= ibmw_pkg::op_t'(operation);
      s1_item.file_block  <= file_block;
      s1_item.read_word   <= read_word;
      s1_item.read_failed <= read_failed;
    end
  end

  ibmw_index_split u_split (
    .file_block   (s1_item.file_block),
    .entries_log2 (entries_log2),
    .split        (split)
  );

  ibmw_step u_step (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .item         (s1_item),
    .split        (split),
    .out_stall    (out_stall),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .kind         (kind_reg),
    .fetch_block  (fetch_block),
    .fetch_index  (fetch_index),
    .mapped_block (mapped_block),
    .error_code   (err_reg)
  );

  assign kind       = kind_reg;
  assign error_code = err_reg;

endmodule

// ===== sv/ibmw_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the indirect block map walker, bound to the top.
// Depends on ibmw_pkg and indirect_block_map_walker.
module ibmw_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  kind,
  input logic [31:0] fetch_block,
  input logic [13:0] fetch_index,
  input logic [1:0]  error_code
);

  // A result is never shown in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(kind) && $stable(error_code)
      && $stable(fetch_block) && $stable(fetch_index))
    else $error("stalled result changed");

  // Error code is set for errors and only for errors.
  a_err_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((kind == ibmw_pkg::KIND_ERR) == (error_code != ibmw_pkg::ERR_NONE)))
    else $error("error code does not match kind");

  // Block-word fetches follow a nonzero pointer only.
  a_word_ptr: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == ibmw_pkg::KIND_WORD |-> fetch_block != 32'd0)
    else $error("fetch of block zero");

  // Inode slot fetches stay inside the inode pointer array.
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == ibmw_pkg::KIND_SLOT |-> fetch_index < 14'(ibmw_pkg::DIRECT_SLOTS + 3))
    else $error("inode slot out of range");

endmodule

bind indirect_block_map_walker ibmw_checker u_ibmw_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .kind        (kind),
  .fetch_block (fetch_block),
  .fetch_index (fetch_index),
  .error_code  (error_code)
);

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for indirect_block_map_walker: directed and random map walks,
// checked against a predictor of the ext2 pointer walk.
// Depends on ibmw_pkg and the walker RTL only.
module tb;
  import ibmw_pkg::*;

  // One result transaction as the walker should present it.
  typedef struct packed {
    kind_t             kind;
    logic [WORD_W-1:0] fetch_block;
    logic [IDX_W-1:0]  fetch_index;
    logic [WORD_W-1:0] mapped_block;
    err_t              error_code;
  } map_result_t;

  // Clock and reset; every walker input starts at a known value.
  logic clk = 1'b0;
  logic rst = 1'b1;

  logic              cfg_we = 1'b0;
  logic [LOG2_W-1:0] cfg_wdata = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              operation = OP_START;
  logic [WORD_W-1:0] file_block = '0;
  logic [WORD_W-1:0] read_word = '0;
  logic              read_failed = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [1:0]        kind;
  logic [WORD_W-1:0] fetch_block;
  logic [IDX_W-1:0]  fetch_index;
  logic [WORD_W-1:0] mapped_block;
  logic [1:0]        error_code;

  // Predictor copy of the walk state and of the pointer-count register.
  logic [LOG2_W-1:0] ptr_log2 = LOG2_W'(MIN_ENTRIES_LOG2);
  logic              in_walk = 1'b0;
  logic [1:0]        tree_depth = '0;
  logic [1:0]        words_fetched = '0;
  logic [IDX_W-1:0]  path_index [LEVELS];

  // Results still owed by the walker, oldest first.
  map_result_t pending_results [$];
  int unsigned items_sent = 0;
  int unsigned mismatch_count = 0;
  int unsigned send_gap_pct = 0;
  int unsigned stall_pct = 0;

  indirect_block_map_walker dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .operation     (operation),
    .file_block    (file_block),
    .read_word     (read_word),
    .read_failed   (read_failed),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .kind          (kind),
    .fetch_block   (fetch_block),
    .fetch_index   (fetch_index),
    .mapped_block  (mapped_block),
    .error_code    (error_code)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Run limit: far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Clamp the pointer-count exponent into the range the tree supports.
  function automatic logic [LOG2_W-1:0] clamp_log2(logic [LOG2_W-1:0] v);
    if (v < LOG2_W'(MIN_ENTRIES_LOG2)) return LOG2_W'(MIN_ENTRIES_LOG2);
    if (v > LOG2_W'(MAX_ENTRIES_LOG2)) return LOG2_W'(MAX_ENTRIES_LOG2);
    return v;
  endfunction

  // Advance the predicted walk by one accepted transaction and return the result it causes.
  function automatic map_result_t predict_map_result(op_t op, logic [WORD_W-1:0] lb,
                                                     logic [WORD_W-1:0] word, logic failed);
    map_result_t     res;
    logic [LOG2_W-1:0] n;
    longint unsigned e, m, r, span2, span3;
    res = '0;
    res.kind = KIND_DONE;
    res.error_code = ERR_NONE;
    if (op == OP_START) begin
      // A start in the middle of a walk drops that walk.
      if (in_walk) begin
        in_walk = 1'b0;
        res.kind = KIND_ERR;
        res.error_code = ERR_ORDER;
        return res;
      end
      n = clamp_log2(ptr_log2);
      e = 64'd1 << n;
      m = e - 1;
      if (lb < DIRECT_SLOTS) begin
        in_walk = 1'b1;
        tree_depth = 2'd0;
        words_fetched = 2'd0;
        res.kind = KIND_SLOT;
        res.fetch_index = IDX_W'(lb);
        return res;
      end
      r = longint'(lb) - DIRECT_SLOTS;
      span2 = e << n;
      span3 = e << (2 * n);
      if (r < e) begin
        tree_depth = 2'd1;
        path_index[0] = IDX_W'(r);
      end else if (r - e < span2) begin
        r = r - e;
        tree_depth = 2'd2;
        path_index[0] = IDX_W'((r >> n) & m);
        path_index[1] = IDX_W'(r & m);
      end else if (r - e - span2 < span3) begin
        r = r - e - span2;
        tree_depth = 2'd3;
        path_index[0] = IDX_W'((r >> (2 * n)) & m);
        path_index[1] = IDX_W'((r >> n) & m);
        path_index[2] = IDX_W'(r & m);
      end else begin
        // Past the triple indirect tree: refuse and stay idle.
        in_walk = 1'b0;
        res.kind = KIND_ERR;
        res.error_code = ERR_RANGE;
        return res;
      end
      in_walk = 1'b1;
      words_fetched = 2'd0;
      res.kind = KIND_SLOT;
      res.fetch_index = IDX_W'(DIRECT_SLOTS + tree_depth - 1);
      return res;
    end
    if (!in_walk) begin
      res.kind = KIND_ERR;
      res.error_code = ERR_ORDER;
    end else if (failed) begin
      in_walk = 1'b0;
      res.kind = KIND_ERR;
      res.error_code = ERR_READ;
    end else if (words_fetched >= tree_depth) begin
      // Last level: the word read is the mapping, zero included.
      in_walk = 1'b0;
      res.mapped_block = word;
    end else if (word == '0) begin
      // Zero pointer above the last level: a hole.
      in_walk = 1'b0;
    end else begin
      res.kind = KIND_WORD;
      res.fetch_block = word;
      res.fetch_index = path_index[words_fetched];
      words_fetched = words_fetched + 2'd1;
    end
    return res;
  endfunction

  // Pick a logical block in a tree tier: 0 direct, 1 single, 2 double, 3 triple,
  // 4 past triple range (falls back to triple where the 32-bit space ends first).
  function automatic logic [WORD_W-1:0] pick_block(int tier, bit at_edge);
    logic [LOG2_W-1:0] n;
    longint unsigned e, base, span, top;
    n = clamp_log2(ptr_log2);
    e = 64'd1 << n;
    top = 64'h1_0000_0000;
    case (tier)
      0: begin
        base = 0;
        span = DIRECT_SLOTS;
      end
      1: begin
        base = DIRECT_SLOTS;
        span = e;
      end
      2: begin
        base = DIRECT_SLOTS + e;
        span = e << n;
      end
      default: begin
        base = DIRECT_SLOTS + e + (e << n);
        span = e << (2 * n);
        if (tier == 4 && base + span < top) begin
          base = base + span;
          span = top - base;
        end else if (base + span > top) begin
          span = top - base;
        end
      end
    endcase
    if (at_edge) return WORD_W'($urandom_range(0, 1) ? base + span - 1 : base);
    return WORD_W'(base + ({$urandom, $urandom} % span));
  endfunction

  // Receiver: stall the result channel at the current rate, fresh each cycle.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // Check every accepted result against the oldest prediction.
  always @(posedge clk) begin
    map_result_t exp;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: kind %0d", kind);
        mismatch_count++;
      end else begin
        exp = pending_results.pop_front();
        if (kind !== exp.kind) begin
          $error("kind: expected %0d, actual %0d", exp.kind, kind);
          mismatch_count++;
        end
        if (fetch_block !== exp.fetch_block) begin
          $error("fetch_block: expected %0h, actual %0h", exp.fetch_block, fetch_block);
          mismatch_count++;
        end
        if (fetch_index !== exp.fetch_index) begin
          $error("fetch_index: expected %0d, actual %0d", exp.fetch_index, fetch_index);
          mismatch_count++;
        end
        if (mapped_block !== exp.mapped_block) begin
          $error("mapped_block: expected %0h, actual %0h", exp.mapped_block, mapped_block);
          mismatch_count++;
        end
        if (error_code !== exp.error_code) begin
          $error("error_code: expected %0d, actual %0d", exp.error_code, error_code);
          mismatch_count++;
        end
      end
    end
  end

  // Send one transaction: idle at the sender's rate, present the payload on a falling
  // edge, hold it until a rising edge with no stall, then predict its result.
  task automatic send_item(op_t op, logic [WORD_W-1:0] lb, logic [WORD_W-1:0] word,
                           logic failed);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    operation <= op;
    file_block <= lb;
    read_word <= word;
    read_failed <= failed;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(predict_map_result(op, lb, word, failed));
    items_sent++;
  endtask

  // Drop valid and wait until every predicted result has come, plus the pipeline depth.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    for (int c = 0; c < 20000 && pending_results.size() != 0; c++) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write the pointer-count register; call only after wait_idle.
  task automatic set_entries(logic [LOG2_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    ptr_log2 = value;
  endtask

  // One map walk: start, then answer each fetch with a pointer word. Now and then
  // return a zero pointer, fail the read, or abandon the walk half way.
  task automatic run_walk(int tier, bit at_edge);
    int roll;
    send_item(OP_START, pick_block(tier, at_edge), $urandom, 1'($urandom_range(0, 1)));
    while (in_walk) begin
      roll = $urandom_range(0, 99);
      if (roll < 4) break;
      if (roll < 9) send_item(OP_RESP, $urandom, $urandom, 1'b1);
      else if (roll < 15) send_item(OP_RESP, $urandom, '0, 1'b0);
      else send_item(OP_RESP, $urandom, $urandom, 1'b0);
    end
  endtask

  // Mostly well-formed walks over all tiers; the rest is noise in any order.
  task automatic run_random(int unsigned count);
    int unsigned stop;
    int roll;
    stop = items_sent + count;
    while (items_sent < stop) begin
      roll = $urandom_range(0, 99);
      if (roll < 8)
        send_item($urandom_range(0, 1) ? OP_RESP : OP_START, $urandom, $urandom,
                  1'($urandom_range(0, 1)));
      else if (roll < 14) run_walk(4, 1'($urandom_range(0, 1)));
      else run_walk($urandom_range(0, 3), $urandom_range(0, 3) == 0);
    end
  endtask

  // Direct slots at the reset pointer count: the slot word is the mapping.
  task automatic test_direct_slots();
    send_item(OP_START, 32'd0, '0, 1'b0);
    send_item(OP_RESP, '0, 32'hFFFF_FFFF, 1'b0);
    send_item(OP_START, 32'd11, '0, 1'b0);
    send_item(OP_RESP, '0, 32'd0, 1'b0);
  endtask

  // Tier boundaries with 256 pointers per block: single first, double last
  // ending in a hole, triple last, then the first and last block past range.
  task automatic test_indirect_levels();
    send_item(OP_START, 32'd12, '0, 1'b0);
    send_item(OP_RESP, '0, 32'hFFFF_FFFF, 1'b0);
    send_item(OP_RESP, '0, 32'h0000_1234, 1'b0);
    send_item(OP_START, 32'd65803, '0, 1'b0);
    send_item(OP_RESP, '0, 32'd5, 1'b0);
    send_item(OP_RESP, '0, 32'd0, 1'b0);
    send_item(OP_START, 32'd16843019, '0, 1'b0);
    send_item(OP_RESP, '0, 32'd1, 1'b0);
    send_item(OP_RESP, '0, 32'd2, 1'b0);
    send_item(OP_RESP, '0, 32'd3, 1'b0);
    send_item(OP_RESP, '0, 32'd4, 1'b0);
    send_item(OP_START, 32'd16843020, '0, 1'b0);
    send_item(OP_START, 32'hFFFF_FFFF, '0, 1'b0);
  endtask

  // Ordering and read errors: response while idle, failed read, start while busy.
  task automatic test_protocol_errors();
    send_item(OP_RESP, '0, 32'd77, 1'b0);
    send_item(OP_START, 32'd100, '0, 1'b0);
    send_item(OP_RESP, '0, 32'd9, 1'b1);
    send_item(OP_START, 32'd20, '0, 1'b0);
    send_item(OP_START, 32'd30, '0, 1'b0);
    send_item(OP_RESP, '0, 32'd9, 1'b0);
  endtask

  // Register extremes, out-of-range values included, each with edge walks on every tier.
  task automatic test_entries_extremes();
    logic [LOG2_W-1:0] values [4];
    values = '{4'd14, 4'd0, 4'd15, 4'd8};
    send_gap_pct = 22;
    stall_pct = 22;
    foreach (values[i]) begin
      wait_idle();
      set_entries(values[i]);
      for (int t = 0; t <= 4; t++) run_walk(t, 1'b1);
    end
  endtask

  // Random walks under each idling pattern, draining and retuning between phases.
  task automatic test_idle_phases();
    int unsigned gaps [4];
    int unsigned stalls [4];
    gaps = '{0, 63, 0, 22};
    stalls = '{0, 0, 63, 22};
    for (int p = 0; p < 4; p++) begin
      wait_idle();
      set_entries(LOG2_W'($urandom_range(0, 15)));
      send_gap_pct = gaps[p];
      stall_pct = stalls[p];
      run_random(110);
    end
  endtask

  initial begin
    foreach (path_index[i]) path_index[i] = '0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    test_direct_slots();
    test_indirect_levels();
    test_protocol_errors();
    test_entries_extremes();
    test_idle_phases();
    wait_idle();
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
